>>> rtl/core/smsa_pkg.sv
// Shared operation and error codes of the scale arithmetic core.
package smsa_pkg;

   typedef enum logic [1:0] {
      FUNC_MUL = 2'd0,
      FUNC_DIV = 2'd1,
      FUNC_GT  = 2'd2,
      FUNC_NE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_ZERO  = 2'd1,
      ERR_RANGE = 2'd2
   } err_type;

endpackage

>>> rtl/core/smsa_if.sv
// Request and response channel interfaces of the scale arithmetic core.
interface smsa_req_if #(
   parameter int FRACT_BITS = 15,
   parameter int SHIFT_BITS = 6
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   func;
   logic [FRACT_BITS-1:0]        a_fract;
   logic signed [SHIFT_BITS-1:0] a_shift;
   logic [FRACT_BITS-1:0]        b_fract;
   logic signed [SHIFT_BITS-1:0] b_shift;

   modport source (output valid, func, a_fract, a_shift, b_fract, b_shift, input ready);
   modport sink (input valid, func, a_fract, a_shift, b_fract, b_shift, output ready);
endinterface

interface smsa_rsp_if #(
   parameter int FRACT_BITS = 15,
   parameter int SHIFT_BITS = 6
);
   logic                         valid;
   logic                         ready;
   logic [FRACT_BITS-1:0]        r_fract;
   logic signed [SHIFT_BITS-1:0] r_shift;
   logic                         cmp_true;
   logic [1:0]                   error_code;

   modport source (output valid, r_fract, r_shift, cmp_true, error_code, input ready);
   modport sink (input valid, r_fract, r_shift, cmp_true, error_code, output ready);
endinterface

>>> rtl/core/smsa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband delay line.
module smsa_div #(
   parameter int FRACT_BITS = 15,
   parameter int SIDE_BITS  = 44
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic [FRACT_BITS-1:0]   num_hi,
   input  logic [FRACT_BITS-1:0]   den,
   input  logic [SIDE_BITS-1:0]    side_in,
   output logic                    out_valid,
   output logic [2*FRACT_BITS-1:0] quo,
   output logic [SIDE_BITS-1:0]    side_out
);

   localparam int D = 2 * FRACT_BITS;

   logic                  vld_ff  [D];
   logic [FRACT_BITS-1:0] rem_ff  [D];
   logic [D-1:0]          num_ff  [D];
   logic [D-1:0]          quo_ff  [D];
   logic [FRACT_BITS-1:0] den_ff  [D];
   logic [SIDE_BITS-1:0]  side_ff [D];

   logic                  vld_in  [D];
   logic [FRACT_BITS-1:0] rem_in  [D];
   logic [D-1:0]          num_in  [D];
   logic [D-1:0]          quo_in  [D];
   logic [FRACT_BITS-1:0] den_in  [D];
   logic [SIDE_BITS-1:0]  side_in_s [D];

   for (genvar i = 0; i < D; i++) begin : g_stage
      logic                  pv;
      logic [FRACT_BITS-1:0] pr;
      logic [D-1:0]          pn;
      logic [D-1:0]          pq;
      logic [FRACT_BITS-1:0] pd;
      logic [SIDE_BITS-1:0]  ps;
      logic [FRACT_BITS:0]   t;
      logic [FRACT_BITS:0]   diff;
      logic                  ge;

      if (i == 0) begin : g_first
         assign pv = in_valid;
         assign pr = '0;
         assign pn = {num_hi, {FRACT_BITS{1'b0}}};
         assign pq = '0;
         assign pd = den;
         assign ps = side_in;
      end else begin : g_next
         assign pv = vld_ff[i-1];
         assign pr = rem_ff[i-1];
         assign pn = num_ff[i-1];
         assign pq = quo_ff[i-1];
         assign pd = den_ff[i-1];
         assign ps = side_ff[i-1];
      end

      always_comb begin
         t            = {pr, pn[D-1]};
         diff         = t - {1'b0, pd};
         ge           = (t >= {1'b0, pd});
         vld_in[i]    = pv;
         rem_in[i]    = ge ? diff[FRACT_BITS-1:0] : t[FRACT_BITS-1:0];
         num_in[i]    = pn << 1;
         quo_in[i]    = {pq[D-2:0], ge};
         den_in[i]    = pd;
         side_in_s[i] = ps;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[i]  <= rem_in[i];
            num_ff[i]  <= num_in[i];
            quo_ff[i]  <= quo_in[i];
            den_ff[i]  <= den_in[i];
            side_ff[i] <= side_in_s[i];
         end
      end
   end

   assign out_valid = vld_ff[D-1];
   assign quo       = quo_ff[D-1];
   assign side_out  = side_ff[D-1];

endmodule

>>> rtl/core/smsa_post.sv
// Normalization, compare and result stages that follow the divider.
module smsa_post #(
   parameter int FRACT_BITS = 15,
   parameter int SHIFT_BITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [2*FRACT_BITS-1:0]      quo,
   input  logic [1:0]                   func,
   input  logic [FRACT_BITS-1:0]        fa,
   input  logic signed [SHIFT_BITS-1:0] sa,
   input  logic [FRACT_BITS-1:0]        fb,
   input  logic signed [SHIFT_BITS-1:0] sb,
   output logic                         out_valid,
   output logic [FRACT_BITS-1:0]        r_fract,
   output logic signed [SHIFT_BITS-1:0] r_shift,
   output logic                         cmp_true,
   output logic [1:0]                   error_code
);

   localparam int F    = FRACT_BITS;
   localparam int S    = SHIFT_BITS;
   localparam int D    = 2 * F;
   localparam int EW   = S + $clog2(D) + 3;
   localparam int CAP  = F + 1;
   localparam int AW   = $clog2(CAP + 1);
   localparam int LW   = D + 2;
   localparam int SMIN = -(1 << (S - 1));
   localparam int SMAX = (1 << (S - 1)) - 1;

   function automatic int lod_f(input logic [F-1:0] v);
      int r;
      r = 0;
      for (int j = 0; j < F; j++) begin
         if (v[j]) begin
            r = j;
         end
      end
      return r;
   endfunction

   // Stage one.
   logic                 v1_ff;
   logic [1:0]           func1_ff, func1_in;
   logic                 za1_ff, zb1_ff;
   logic [D-1:0]         p1_ff, p1_in;
   logic [D-1:0]         q1_ff;
   logic signed [EW-1:0] ssum1_ff, ssum1_in;
   logic signed [EW-1:0] sdif1_ff, sdif1_in;
   logic signed [EW-1:0] n1_ff, n1_in;
   logic [LW-1:0]        lhs1_ff, lhs1_in, rhs1_ff, rhs1_in;
   logic signed [S:0]    d;
   logic [S:0]           dmag;
   logic [AW-1:0]        amt;

   always_comb begin
      func1_in = func;
      p1_in    = D'(fa) * D'(fb);
      ssum1_in = EW'(sa) + EW'(sb);
      sdif1_in = EW'(sa) - EW'(sb);
      if (quo[D-1:F] == '0) begin
         n1_in = '0;
      end else begin
         n1_in = EW'(lod_f(quo[D-1:F]) + 1);
      end
      d    = (S+1)'(sa) - (S+1)'(sb);
      dmag = (d < 0) ? $unsigned(-d) : $unsigned(d);
      if (dmag > (S+1)'(CAP)) begin
         amt = AW'(CAP);
      end else begin
         amt = AW'(dmag);
      end
      lhs1_in = LW'(fa);
      rhs1_in = LW'(fb);
      if (fa != '0 && fb != '0) begin
         if (d >= 0) begin
            lhs1_in = LW'(fa) << amt;
         end else begin
            rhs1_in = LW'(fb) << amt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         func1_ff <= func1_in;
         za1_ff   <= (fa == '0);
         zb1_ff   <= (fb == '0);
         p1_ff    <= p1_in;
         q1_ff    <= quo;
         ssum1_ff <= ssum1_in;
         sdif1_ff <= sdif1_in;
         n1_ff    <= n1_in;
         lhs1_ff  <= lhs1_in;
         rhs1_ff  <= rhs1_in;
      end
   end

   // Stage two.
   logic                 v2_ff;
   logic [1:0]           func2_ff;
   logic                 za2_ff, zb2_ff;
   logic [F-1:0]         mf2_ff, mf2_in, df2_ff, df2_in;
   logic signed [EW-1:0] ms2_ff, ms2_in, ds2_ff, ds2_in;
   logic                 gt2_ff, ne2_ff;
   logic signed [EW-1:0] n;
   logic [D-1:0]         qs;

   always_comb begin
      if (p1_ff[D-1:F] != '0) begin
         mf2_in = p1_ff[D-1:F];
         ms2_in = ssum1_ff;
      end else begin
         mf2_in = F'(1);
         ms2_in = ssum1_ff - EW'(F - lod_f(p1_ff[F-1:0]));
      end
      n = (-sdif1_ff > n1_ff) ? -sdif1_ff : n1_ff;
      if (n >= EW'(D)) begin
         qs = '0;
      end else begin
         qs = q1_ff >> $unsigned(n);
      end
      df2_in = qs[F-1:0];
      ds2_in = sdif1_ff + n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         func2_ff <= func1_ff;
         za2_ff   <= za1_ff;
         zb2_ff   <= zb1_ff;
         mf2_ff   <= mf2_in;
         ms2_ff   <= ms2_in;
         df2_ff   <= df2_in;
         ds2_ff   <= ds2_in;
         gt2_ff   <= (lhs1_ff > rhs1_ff);
         ne2_ff   <= (lhs1_ff != rhs1_ff);
      end
   end

   // Stage three is the response register.
   logic                 v3_ff;
   logic [F-1:0]         rf3_ff, rf3_in;
   logic signed [S-1:0]  rs3_ff, rs3_in;
   logic                 cmp3_ff, cmp3_in;
   logic [1:0]           err3_ff, err3_in;
   logic signed [EW-1:0] rs_w;

   always_comb begin
      rf3_in  = '0;
      rs_w    = '0;
      cmp3_in = 1'b0;
      err3_in = smsa_pkg::ERR_OK;
      case (func2_ff)
         smsa_pkg::FUNC_MUL: begin
            rf3_in = mf2_ff;
            rs_w   = ms2_ff;
            if (za2_ff || zb2_ff) begin
               err3_in = smsa_pkg::ERR_ZERO;
            end
         end
         smsa_pkg::FUNC_DIV: begin
            rf3_in = df2_ff;
            rs_w   = ds2_ff;
            if (zb2_ff) begin
               err3_in = smsa_pkg::ERR_ZERO;
            end
         end
         smsa_pkg::FUNC_GT: begin
            cmp3_in = gt2_ff;
         end
         default: begin
            cmp3_in = ne2_ff;
         end
      endcase
      if (err3_in == smsa_pkg::ERR_OK && (func2_ff == smsa_pkg::FUNC_MUL ||
          func2_ff == smsa_pkg::FUNC_DIV) && (rs_w < SMIN || rs_w > SMAX)) begin
         err3_in = smsa_pkg::ERR_RANGE;
      end
      if (err3_in != smsa_pkg::ERR_OK) begin
         rf3_in = '0;
         rs_w   = '0;
      end
      rs3_in = rs_w[S-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rf3_ff  <= rf3_in;
         rs3_ff  <= rs3_in;
         cmp3_ff <= cmp3_in;
         err3_ff <= err3_in;
      end
   end

   assign out_valid  = v3_ff;
   assign r_fract    = rf3_ff;
   assign r_shift    = rs3_ff;
   assign cmp_true   = cmp3_ff;
   assign error_code = err3_ff;

endmodule

>>> rtl/core/scale_mantissa_shift_alu_core.sv
// Top level of the scale multiply, divide and compare core.
//
//   channel   direction  transfer carries
//   req_ch    in         func, a_fract, a_shift, b_fract, b_shift
//   rsp_ch    out        r_fract, r_shift, cmp_true, error_code
//
// One item can enter every cycle unless a response waits untaken; the divider, which
// resolves one quotient bit per stage, is followed by three result stages.
// Reset clears only the valid bits of the stages.
// When a response waits untaken, every stage holds and req_ch.ready is low.
module scale_mantissa_shift_alu_core #(
   parameter int FRACT_BITS = 15,
   parameter int SHIFT_BITS = 6
) (
   input logic         clock,
   input logic         reset,
   smsa_req_if.sink    req_ch,
   smsa_rsp_if.source  rsp_ch
);

   localparam int SIDE_BITS = 2 + 2 * FRACT_BITS + 2 * SHIFT_BITS;

   logic                         adv;
   logic                         dv;
   logic [2*FRACT_BITS-1:0]      dq;
   logic [SIDE_BITS-1:0]         side_i, side_o;
   logic [1:0]                   s_func;
   logic [FRACT_BITS-1:0]        s_fa, s_fb;
   logic signed [SHIFT_BITS-1:0] s_sa, s_sb;

   assign adv          = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = adv;
   assign side_i = {req_ch.func, req_ch.a_fract, req_ch.a_shift, req_ch.b_fract,
                    req_ch.b_shift};
   assign {s_func, s_fa, s_sa, s_fb, s_sb} = side_o;

   smsa_div #(
      .FRACT_BITS (FRACT_BITS),
      .SIDE_BITS  (SIDE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .num_hi    (req_ch.a_fract),
      .den       (req_ch.b_fract),
      .side_in   (side_i),
      .out_valid (dv),
      .quo       (dq),
      .side_out  (side_o)
   );

   smsa_post #(
      .FRACT_BITS (FRACT_BITS),
      .SHIFT_BITS (SHIFT_BITS)
   ) u_post (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (dv),
      .quo        (dq),
      .func       (s_func),
      .fa         (s_fa),
      .sa         (s_sa),
      .fb         (s_fb),
      .sb         (s_sb),
      .out_valid  (rsp_ch.valid),
      .r_fract    (rsp_ch.r_fract),
      .r_shift    (rsp_ch.r_shift),
      .cmp_true   (rsp_ch.cmp_true),
      .error_code (rsp_ch.error_code)
   );

`ifndef ASSERT_OFF
   a_err_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.error_code != smsa_pkg::ERR_OK |->
         rsp_ch.r_fract == '0 && rsp_ch.r_shift == '0 && !rsp_ch.cmp_true)
      else $error("error response carries a nonzero result");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.cmp_true |->
         rsp_ch.r_fract == '0 && rsp_ch.r_shift == '0)
      else $error("compare response carries a scale");

   a_hold_stall: assert property (@(posedge clock) disable iff (reset)
      dv && !adv |=> dv && $stable(dq))
      else $error("divider output moved during a stall");
`endif

endmodule
